>>> rtl/scored_substring_match_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scored substring matcher
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SCORED_SUBSTRING_MATCH_MACROS_SVH
`define SCORED_SUBSTRING_MATCH_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every edge.
`define SSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("scored_substring_match: invariant violated");
// Antecedent implies consequent at the next edge.
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scored_substring_match: sequence check failed");
`else
`define SSM_ASSERT(lbl, prop)
`define SSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Types, codes and helpers shared by the matcher cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  // Request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_BYTE  = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  // Match grades
  localparam logic [1:0] GRADE_NONE   = 2'd0;
  localparam logic [1:0] GRADE_SUB    = 2'd1;
  localparam logic [1:0] GRADE_WORD   = 2'd2;
  localparam logic [1:0] GRADE_PREFIX = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] item_number;
  } ssm_in_t;

  typedef struct packed {
    logic [7:0] item_id;
    logic [1:0] match_grade;
  } ssm_out_t;

  // Per-transaction control broadcast to every cell
  typedef struct packed {
    logic shift_item;   // item byte enters the window
    logic drop_item;    // window empties
    logic load_query;   // query byte enters the query chain
    logic clear_query;  // query chain empties
  } ssm_ctrl_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic [7:0] rec;    // raw item byte
    logic       seen;   // slot holds a real item byte
    logic [7:0] qry;    // lowercased query byte
    logic       qv;     // slot holds a query byte
  } ssm_link_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E);
  endfunction

endpackage

`default_nettype wire

>>> rtl/scored_substring_match.sv
// ----------------------------------------------------------------------------
// scored_substring_match
// Grades how well a query matches a text item, ignoring ASCII case.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries requests:
//   clear query, append query byte, item byte, end of item. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries one transaction per end
//   of item: the echoed item number and the best grade (3 prefix, 2 word
//   start, 1 substring, 0 none; an empty query always grades 1).
//   Throughput is one request per cycle. Each item byte is graded in the
//   cycle after it is taken, from the registered window; an end of item in
//   that cycle folds that pending grade in directly.
//   The result is registered and shows in the cycle after the end of item
//   transaction is taken.
//   The window is a chain of QUERY_CAP+1 cells; the compare of all cells
//   against the query and the reduction to one grade set the cycle path.
//   Reset empties query and window; no result is pending.
//   While a result waits and out_stall_i is high, in_stall_o is high too;
//   otherwise requests keep flowing behind a waiting result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scored_substring_match_macros.svh"

module scored_substring_match import ssm_pkg::*; #(
  parameter int QUERY_CAP = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ssm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ssm_out_t out_data_o
);

  localparam int NCELL = QUERY_CAP + 1;

  logic       in_acc;
  ssm_ctrl_t  ctrl;
  ssm_link_t  link [NCELL+1];
  logic [NCELL-1:0] ok_vec, qv_vec, sv_vec;
  logic [1:0] cell_grade [NCELL];
  logic [1:0] bnd_grade, eval_grade, cur_best;
  logic       hit;

  logic       out_valid_q, out_valid_d;
  ssm_out_t   out_q;
  logic [1:0] best_q, best_d;
  logic       pend_q, pend_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Decode the request into the cell controls
  always_comb begin
    ctrl = '0;
    if (in_acc) begin
      unique case (in_data_i.req_type)
        REQ_CLEAR: begin
          ctrl.drop_item   = 1'b1;
          ctrl.clear_query = 1'b1;
        end
        REQ_QUERY: ctrl.load_query = ~qv_vec[QUERY_CAP-1]; // overflow ignored
        REQ_BYTE:  ctrl.shift_item = 1'b1;
        REQ_END:   ctrl.drop_item  = 1'b1;
        default:   ctrl = '0;
      endcase
    end
  end

  // Head of the chain: new item byte raw, new query byte folded
  assign link[0] = '{rec: in_data_i.data_byte, seen: 1'b1,
                     qry: fold(in_data_i.data_byte), qv: 1'b1};

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    ssm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .link_i  (link[j]),
      .link_o  (link[j+1]),
      .ok_o    (ok_vec[j]),
      .grade_o (cell_grade[j])
    );
    assign qv_vec[j] = link[j+1].qv;
    assign sv_vec[j] = link[j+1].seen;
  end

  // Exactly one cell marks the end of a non-empty query
  always_comb begin
    bnd_grade = GRADE_NONE;
    for (int j = 0; j < NCELL; j++) begin
      bnd_grade = bnd_grade | cell_grade[j];
    end
  end

  assign hit        = qv_vec[0] & (&ok_vec);
  assign eval_grade = hit ? bnd_grade : GRADE_NONE;
  assign cur_best   = (pend_q && (eval_grade > best_q)) ? eval_grade : best_q;

  always_comb begin
    best_d      = ctrl.drop_item ? GRADE_NONE : cur_best;
    pend_d      = ctrl.shift_item;
    out_valid_d = out_valid_q & out_stall_i;
    if (in_acc && (in_data_i.req_type == REQ_END)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      best_q      <= GRADE_NONE;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      best_q      <= best_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.req_type == REQ_END)) begin
      out_q.item_id     <= in_data_i.item_number;
      out_q.match_grade <= qv_vec[0] ? cur_best : GRADE_SUB;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Query and window occupancy fill from cell 0 without gaps
  `SSM_ASSERT(a_qv_thermo, (qv_vec & (qv_vec + {{QUERY_CAP{1'b0}}, 1'b1})) == '0)
  `SSM_ASSERT(a_sv_thermo, (sv_vec & (sv_vec + {{QUERY_CAP{1'b0}}, 1'b1})) == '0)
  // The spare cell never holds a query byte
  `SSM_ASSERT(a_qv_cap, !qv_vec[QUERY_CAP])
  `SSM_ASSERT_NEXT(a_clear, in_acc && (in_data_i.req_type == REQ_CLEAR),
                   (qv_vec == '0) && (sv_vec == '0) && (best_q == GRADE_NONE))
  `SSM_ASSERT_NEXT(a_end_out, in_acc && (in_data_i.req_type == REQ_END),
                   out_valid_q && !pend_q)

endmodule

`default_nettype wire

>>> rtl/ssm_cell.sv
// ----------------------------------------------------------------------------
// ssm_cell
// One slot of the item window paired with one slot of the reversed query.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_cell import ssm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssm_ctrl_t  ctrl_i,
  input  ssm_link_t  link_i,
  output ssm_link_t  link_o,
  output logic       ok_o,
  output logic [1:0] grade_o
);

  logic [7:0] rec_q, qry_q;
  logic       seen_q, qv_q;

  // Flags reset; byte payloads are gated by them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      qv_q   <= 1'b0;
    end else begin
      if (ctrl_i.drop_item) begin
        seen_q <= 1'b0;
      end else if (ctrl_i.shift_item) begin
        seen_q <= link_i.seen;
      end
      if (ctrl_i.clear_query) begin
        qv_q <= 1'b0;
      end else if (ctrl_i.load_query) begin
        qv_q <= link_i.qv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_item) begin
      rec_q <= link_i.rec;
    end
    if (ctrl_i.load_query) begin
      qry_q <= link_i.qry;
    end
  end

  assign link_o = '{rec: rec_q, seen: seen_q, qry: qry_q, qv: qv_q};

  // Slot agrees with the query, or lies beyond it
  assign ok_o = !qv_q || (seen_q && (fold(rec_q) == qry_q));

  // First slot past the query: the byte before a match
  always_comb begin
    grade_o = GRADE_NONE;
    if (link_i.qv && !qv_q) begin
      if (!seen_q) begin
        grade_o = GRADE_PREFIX;
      end else if (is_sep(rec_q)) begin
        grade_o = GRADE_WORD;
      end else begin
        grade_o = GRADE_SUB;
      end
    end
  end

endmodule

`default_nettype wire
